FILE: hdl/sadq_pkg.sv
`default_nettype none
package sadq_pkg;

   localparam int DATA_W      = 16;
   localparam int TIME_W      = 32;
   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REJECTED = 2'd1;
   localparam logic [1:0] KIND_EXPIRED  = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [DATA_W-1:0] delay;
      logic [DATA_W-1:0] tag;
   } entry_type;

   // wrap-safe compare: a is at or after b
   function automatic logic at_or_after(input logic [TIME_W-1:0] a,
                                        input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = a - b;
      return ~d[TIME_W-1];
   endfunction

endpackage
`default_nettype wire

FILE: hdl/sadq_mem.sv
`default_nettype none
module sadq_mem
   import sadq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire entry_type                wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      entry_type                rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/sorted_alarm_deadline_queue.sv
// Sorted alarm queue held in one memory used as a ring from a head pointer, kept in
// ascending deadline order. An insert (req_tuser 0) moves every queued entry whose
// deadline is at or after the new one, since each of those is read and written one
// slot back through the single memory port pair, and then writes the new entry. A
// full queue rejects the insert. An insert gives one item, kind 0 or 1. A tick
// (req_tuser 1) advances the seconds counter and then, for each expired alarm, reads
// the head entry and compares it; it stops at an entry not yet due, or when the queue
// runs empty or 16 alarms have gone out. It gives up to 16 items with kind 2, the
// last one marked by rsp_tlast, or none. A stalled rsp_tready holds the work. One
// request is worked at a time; after it the block returns to idle, where the next
// request can be taken.
`default_nettype none
module sorted_alarm_deadline_queue
   import sadq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,  // delay_seconds[15:0], alarm_id[31:16]
   input  wire logic        req_tuser,  // cmd
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,  // out_tag[15:0], out_delay[31:16]
   output      logic [1:0]  rsp_tuser,  // kind
   output      logic        rsp_tlast
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_INS_READ, ST_INS_CMP, ST_RESP, ST_TICK_READ, ST_TICK_CMP
   } state_type;

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [RES_W-1:0]  nres_ff, nres_in;
   logic [1:0]        kind_ff, kind_in;
   entry_type         new_ff, new_in;
   entry_type         pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0] rsp_tag_ff, rsp_tag_in;
   logic [DATA_W-1:0] rsp_delay_ff, rsp_delay_in;
   logic              rsp_last_ff, rsp_last_in;

   logic             wr_en, rd_en, out_free, due;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] l);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(head) + (CNT_W+1)'(l);
      if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         s = s - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return s[IDX_W-1:0];
   endfunction

   sadq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign due        = at_or_after(now_ff, rd_data.deadline);

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      nres_in       = nres_ff;
      kind_in       = kind_ff;
      new_in        = new_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = phys(head_ff, pos_ff);
      wr_data       = new_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_TICK) begin
                  now_in        = now_ff + 1'b1;
                  nres_in       = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_TICK_READ;
               end else begin
                  new_in.deadline = now_ff + TIME_W'(req_tdata[15:0]);
                  new_in.delay    = req_tdata[15:0];
                  new_in.tag      = req_tdata[31:16];
                  pos_in          = count_ff;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     kind_in  = KIND_REJECTED;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_INS_READ;
                  end
               end
            end
         end
         ST_INS_READ: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               kind_in  = KIND_ACCEPTED;
               state_in = ST_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys(head_ff, pos_ff - 1'b1);
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (at_or_after(rd_data.deadline, new_ff.deadline)) begin
               wr_data  = rd_data;
               pos_in   = pos_ff - 1'b1;
               state_in = ST_INS_READ;
            end else begin
               count_in = count_ff + 1'b1;
               kind_in  = KIND_ACCEPTED;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_tag_in   = new_ff.tag;
               rsp_delay_in = new_ff.delay;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TICK_READ: begin
            if (count_ff == '0 || nres_ff == RES_W'(MAX_RESULTS)) begin
               if (!pend_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_EXPIRED;
                  rsp_tag_in    = pend_ff.tag;
                  rsp_delay_in  = pend_ff.delay;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = ST_TICK_CMP;
            end
         end
         ST_TICK_CMP: begin
            if (due) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_EXPIRED;
                     rsp_tag_in   = pend_ff.tag;
                     rsp_delay_in = pend_ff.delay;
                     rsp_last_in  = 1'b0;
                  end
                  pend_in       = rd_data;
                  pend_valid_in = 1'b1;
                  head_in       = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : head_ff + 1'b1;
                  count_in      = count_ff - 1'b1;
                  nres_in       = nres_ff + 1'b1;
                  state_in      = ST_TICK_READ;
               end
            end else if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_EXPIRED;
               rsp_tag_in    = pend_ff.tag;
               rsp_delay_in  = pend_ff.delay;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pos_ff       <= pos_in;
      nres_ff      <= nres_in;
      kind_ff      <= kind_in;
      new_ff       <= new_in;
      pend_ff      <= pend_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_delay_ff <= rsp_delay_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_delay_ff, rsp_tag_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire
